/* hdl/mmh_pkg.sv */
// Shared types, constants and helper functions of the MurmurHash2 block.
`timescale 1ns / 1ps
`default_nettype none

package mmh_pkg;

  // Mixing constants
  localparam logic [31:0] MixMul     = 32'h5bd1e995;
  localparam int unsigned MixShift   = 24;
  localparam int unsigned FinShiftA  = 13;
  localparam int unsigned FinShiftB  = 15;
  localparam logic [31:0] SeedReset  = 32'h9747b28c;

  // Configuration register decode (word index taken from paddr[2])
  localparam logic        RegIdxHashSeed = 1'b0;

  // Default depth of the queue between front and back
  localparam int unsigned QueueDepth = 2;

  // What the back end does with a word
  typedef enum logic [1:0] {
    OP_NONE,
    OP_BLOCK,
    OP_TAIL
  } op_e;

  // Back end sequencer states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MIX,
    BK_FIN,
    BK_EMIT
  } back_state_e;

  // One classified word as it travels from front to back
  typedef struct packed {
    logic        start;
    logic [31:0] init;
    op_e         op;
    logic [31:0] word;
    logic        last;
  } entry_t;

  // Sort a word by its byte count; counts above four act as four
  function automatic op_e classify(input logic [2:0] cnt);
    op_e op;
    if (cnt == 3'd0) begin
      op = OP_NONE;
    end else if (cnt >= 3'd4) begin
      op = OP_BLOCK;
    end else begin
      op = OP_TAIL;
    end
    return op;
  endfunction

  // Keep only the valid tail bytes
  function automatic logic [31:0] tail_mask(input logic [2:0] cnt);
    logic [31:0] mask;
    unique case (cnt)
      3'd1:    mask = 32'h0000_00ff;
      3'd2:    mask = 32'h0000_ffff;
      default: mask = 32'h00ff_ffff;
    endcase
    return mask;
  endfunction

endpackage

`default_nettype wire

/* hdl/mmh_front.sv */
// Front end: accepts key words, classifies them and premixes full blocks.
`timescale 1ns / 1ps
`default_nettype none

module mmh_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push,
  output logic                 full,
  input  wire logic            start_req_i,
  input  wire logic [31:0]     key_length_i,
  input  wire logic [31:0]     data_word_i,
  input  wire logic [2:0]      byte_count_i,
  input  wire logic            last_i,
  input  wire logic [31:0]     hash_seed_i,
  output mmh_pkg::entry_t      ent_o,
  output logic                 ent_push_o,
  input  wire logic            q_full_i
);

  logic            s1_v_q, s1_v_d;
  logic            s2_v_q, s2_v_d;
  mmh_pkg::entry_t s1_q, s1_d;
  mmh_pkg::entry_t s2_q, s2_d;
  logic            adv1, adv2, accept;
  mmh_pkg::op_e    in_op;
  logic [31:0]     k_shuf;

  // Stage hand-off: a stage loads when it is empty or its content moves on
  assign adv2   = !s2_v_q || !q_full_i;
  assign adv1   = !s1_v_q || adv2;
  assign full   = !adv1;
  assign accept = push && adv1;

  // Stage 1: classify, seed, first multiply of a full block
  always_comb begin
    in_op      = mmh_pkg::classify(byte_count_i);
    s1_d       = s1_q;
    s1_v_d     = s1_v_q;
    if (adv1) begin
      s1_v_d = push;
    end
    if (accept) begin
      s1_d.start = start_req_i;
      s1_d.init  = hash_seed_i ^ key_length_i;
      s1_d.op    = in_op;
      s1_d.last  = last_i;
      if (in_op == mmh_pkg::OP_BLOCK) begin
        s1_d.word = data_word_i * mmh_pkg::MixMul;
      end else begin
        s1_d.word = data_word_i & mmh_pkg::tail_mask(byte_count_i);
      end
    end
  end

  // Stage 2: shift-xor and second multiply of a full block
  always_comb begin
    k_shuf = s1_q.word ^ (s1_q.word >> mmh_pkg::MixShift);
    s2_d   = s2_q;
    s2_v_d = s2_v_q;
    if (adv2) begin
      s2_v_d = s1_v_q;
      s2_d   = s1_q;
      if (s1_q.op == mmh_pkg::OP_BLOCK) begin
        s2_d.word = k_shuf * mmh_pkg::MixMul;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= s1_v_d;
      s2_v_q <= s2_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q <= s1_d;
    s2_q <= s2_d;
  end

  assign ent_o      = s2_q;
  assign ent_push_o = s2_v_q && !q_full_i;

endmodule

`default_nettype wire

/* hdl/mmh_fifo.sv */
// Short register queue between front and back end.
`timescale 1ns / 1ps
`default_nettype none

module mmh_fifo #(
  parameter int unsigned Depth = mmh_pkg::QueueDepth
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire mmh_pkg::entry_t wdata_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output mmh_pkg::entry_t      rdata_o,
  output logic                 valid_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  mmh_pkg::entry_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign rdata_o = mem_q[rd_q];

  // Advance pointers with wrap and track the fill level
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

/* hdl/mmh_back.sv */
// Back end: merges words into the running hash, finalizes and holds the result.
`timescale 1ns / 1ps
`default_nettype none

module mmh_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire mmh_pkg::entry_t ent_i,
  input  wire logic            ent_valid_i,
  output logic                 ent_pop_o,
  output logic                 empty,
  input  wire logic            pop,
  output logic [31:0]          hash_value_o
);

  mmh_pkg::back_state_e state_q, state_d;
  logic [31:0]  run_q, run_d;
  logic [31:0]  t_q, t_d;
  logic [31:0]  k_q, k_d;
  mmh_pkg::op_e op_q, op_d;
  logic         last_q, last_d;
  logic [31:0]  f_q, f_d;
  logic [31:0]  res_q, res_d;
  logic         res_v_q, res_v_d;
  logic [31:0]  h0, h_mix;
  logic         res_take;

  assign res_take = pop && res_v_q;

  always_comb begin
    state_d   = state_q;
    run_d     = run_q;
    t_d       = t_q;
    k_d       = k_q;
    op_d      = op_q;
    last_d    = last_q;
    f_d       = f_q;
    res_d     = res_q;
    res_v_d   = res_v_q && !res_take;
    ent_pop_o = 1'b0;
    h0        = ent_i.start ? ent_i.init : run_q;
    h_mix     = (op_q == mmh_pkg::OP_BLOCK) ? (t_q ^ k_q) : t_q;
    unique case (state_q)
      // Take a word and multiply the hash
      mmh_pkg::BK_IDLE: begin
        if (ent_valid_i) begin
          ent_pop_o = 1'b1;
          k_d       = ent_i.word;
          op_d      = ent_i.op;
          last_d    = ent_i.last;
          unique case (ent_i.op)
            mmh_pkg::OP_BLOCK: t_d = h0 * mmh_pkg::MixMul;
            mmh_pkg::OP_TAIL:  t_d = (h0 ^ ent_i.word) * mmh_pkg::MixMul;
            default:           t_d = h0;
          endcase
          state_d = mmh_pkg::BK_MIX;
        end
      end
      // Merge a full block, update the running hash, start the finalizer on a last word
      mmh_pkg::BK_MIX: begin
        run_d = h_mix;
        if (last_q) begin
          f_d     = h_mix ^ (h_mix >> mmh_pkg::FinShiftA);
          state_d = mmh_pkg::BK_FIN;
        end else begin
          state_d = mmh_pkg::BK_IDLE;
        end
      end
      // Finalizer multiply
      mmh_pkg::BK_FIN: begin
        f_d     = f_q * mmh_pkg::MixMul;
        state_d = mmh_pkg::BK_EMIT;
      end
      // Load the output register once it is free
      mmh_pkg::BK_EMIT: begin
        if (!res_v_q || res_take) begin
          res_d   = f_q ^ (f_q >> mmh_pkg::FinShiftB);
          res_v_d = 1'b1;
          state_d = mmh_pkg::BK_IDLE;
        end
      end
      default: state_d = mmh_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mmh_pkg::BK_IDLE;
      run_q   <= '0;
      res_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      run_q   <= run_d;
      res_v_q <= res_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q    <= t_d;
    k_q    <= k_d;
    op_q   <= op_d;
    last_q <= last_d;
    f_q    <= f_d;
    res_q  <= res_d;
  end

  assign empty        = !res_v_q;
  assign hash_value_o = res_q;

endmodule

`default_nettype wire

/* hdl/murmur2_string_hash.sv */
// Top level of the streaming 32-bit MurmurHash2 block.
//
//   channel   direction  handshake               payload
//   words     in         push / full             start_req, key_length, data_word,
//                                                byte_count, last
//   hashes    out        pop / empty             hash_value
//   config    in/out     psel, penable, pwrite   hash_seed at byte address 0
//
// A word passes the front pipeline stages, then waits in the queue. The
// back end multiplies the hash, then merges the word into the running
// hash; a last word then gets the finalizer multiply and the output load.
// Reset sets hash_seed to 0x9747b28c, clears the running hash and empties
// all stages. full rises when the front pipeline and the queue are both
// occupied; a finished hash stays on hash_value_o until it is popped.
`timescale 1ns / 1ps
`default_nettype none

module murmur2_string_hash #(
  parameter int unsigned QueueDepth = mmh_pkg::QueueDepth
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic        start_req_i,
  input  wire logic [31:0] key_length_i,
  input  wire logic [31:0] data_word_i,
  input  wire logic [2:0]  byte_count_i,
  input  wire logic        last_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [31:0]      hash_value_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [31:0]     seed_q, seed_d;
  logic            cfg_wr;
  mmh_pkg::entry_t f2q, q2b;
  logic            f2q_push, q_full, q_valid, q_pop;

  // Configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    seed_d = seed_q;
    if (cfg_wr && (paddr[2] == mmh_pkg::RegIdxHashSeed)) begin
      seed_d = pwdata;
    end
  end

  assign prdata = (paddr[2] == mmh_pkg::RegIdxHashSeed) ? seed_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= mmh_pkg::SeedReset;
    end else begin
      seed_q <= seed_d;
    end
  end

  mmh_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .start_req_i  (start_req_i),
    .key_length_i (key_length_i),
    .data_word_i  (data_word_i),
    .byte_count_i (byte_count_i),
    .last_i       (last_i),
    .hash_seed_i  (seed_q),
    .ent_o        (f2q),
    .ent_push_o   (f2q_push),
    .q_full_i     (q_full)
  );

  mmh_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f2q_push),
    .wdata_i (f2q),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (q2b),
    .valid_o (q_valid)
  );

  mmh_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ent_i        (q2b),
    .ent_valid_i  (q_valid),
    .ent_pop_o    (q_pop),
    .empty        (empty),
    .pop          (pop),
    .hash_value_o (hash_value_o)
  );

endmodule

`default_nettype wire

/* hdl/mmh_checker.sv */
// Port-level checks of the MurmurHash2 block and their binding to the top level.
`timescale 1ns / 1ps
`default_nettype none

module mmh_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        push,
  input wire logic        full,
  input wire logic        last_i,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic [31:0] hash_value_o
);

  logic [7:0] pend_q, pend_d;
  logic       in_last, out_xfer;

  // Count hashes owed: accepted last words minus transferred results
  assign in_last  = push && !full && last_i;
  assign out_xfer = pop && !empty;

  always_comb begin
    pend_d = pend_q;
    if (in_last && !out_xfer) begin
      pend_d = pend_q + 8'd1;
    end else if (out_xfer && !in_last) begin
      pend_d = pend_q - 8'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  // No result without an owed last word
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q == 8'd0) |-> empty)
    else $error("result shown with no last word outstanding");

  // Result appears only after a last word went in
  a_rise_owed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(empty) |-> ($past(pend_q) != 8'd0))
    else $error("result appeared without a preceding last word");

  // Waiting result is not withdrawn
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> !empty)
    else $error("result withdrawn before transfer");

  // Waiting result keeps its value
  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> $stable(hash_value_o))
    else $error("result changed before transfer");

endmodule

bind murmur2_string_hash mmh_checker u_mmh_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .push         (push),
  .full         (full),
  .last_i       (last_i),
  .empty        (empty),
  .pop          (pop),
  .hash_value_o (hash_value_o)
);

`default_nettype wire
